// ===== hdl/sbmc_pkg.sv =====
`default_nettype none

package sbmc_pkg;

   // preamble words of the three sub-frame kinds
   localparam logic [31:0] PRE_B = 32'h3317_3333;
   localparam logic [31:0] PRE_M = 32'h331d_3333;
   localparam logic [31:0] PRE_W = 32'h331b_3333;

   // one pcm sample as two bytes in memory order
   typedef struct packed {
      logic [7:0] first_byte;
      logic [7:0] second_byte;
   } req_type;

   // one encoded sub-frame
   typedef struct packed {
      logic [31:0] preamble_word;
      logic [30:0] data_word;
      logic        block_start;
   } rsp_type;

   // preamble selection carried from the input stage
   typedef struct packed {
      logic block_start;
      logic odd_sample;
   } slot_type;

   // biphase-mark pattern of one byte, lsb first, two cells per bit,
   // last cell ends at level 1
   function automatic logic [15:0] bmc_pattern(input logic [7:0] byte_val);
      logic [15:0] pat;
      logic        level;
      logic        head;
      pat   = '0;
      level = 1'b1;
      for (int i = 7; i >= 0; i--) begin
         head          = level ^ byte_val[i];
         pat[15 - 2*i] = head;
         pat[14 - 2*i] = level;
         level         = ~head;
      end
      return pat;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/sbmc_word_encoder.sv =====
`default_nettype none

module sbmc_word_encoder (
   input  wire sbmc_pkg::req_type  sample,
   input  wire sbmc_pkg::slot_type slot,
   output sbmc_pkg::rsp_type       frame
);

   logic [15:0] hi_pat;
   logic [15:0] lo_pat;
   logic [31:0] word;

   // bmc patterns of both bytes
   assign hi_pat = sbmc_pkg::bmc_pattern(sample.first_byte);
   assign lo_pat = sbmc_pkg::bmc_pattern(sample.second_byte);

   // upper half xor sign-extended lower pattern, bit 31 dropped
   assign word = {hi_pat, 16'h0000} ^ {{16{lo_pat[15]}}, lo_pat};

   // preamble select
   always_comb begin
      frame.data_word   = word[30:0];
      frame.block_start = slot.block_start;
      if (slot.block_start) begin
         frame.preamble_word = sbmc_pkg::PRE_B;
      end else if (slot.odd_sample) begin
         frame.preamble_word = sbmc_pkg::PRE_W;
      end else begin
         frame.preamble_word = sbmc_pkg::PRE_M;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/spdif_bmc_frame_encoder_top.sv =====
// S/PDIF biphase-mark sub-frame encoder.
// Input channel req_: one 16-bit pcm sample per transfer as two bytes in
// memory order. Result channel rsp_: one transfer per sample carrying the
// preamble word (B, M or W), the 31-bit bmc data word and a block start flag.
// Both channels use valid/stall; a transfer happens on a clock edge with
// valid high and stall low.
// Path: an input transfer loads the input register, whose bmc word is then
// loaded into the result register, from which the result transfers.
// Throughput: one sample per cycle while the receiver does not stall, set by
// the combinational pattern lookup and xor between the two registers.
// A sample counter runs over 2*FRAMES_PER_BLOCK samples; sample 0 of each
// block gets B, other even samples M, odd samples W.
// Reset (synchronous, active high) empties both registers and returns the
// counter to sample 0, so the first sample after reset carries B.
// When the receiver stalls, the result register holds its transfer, the
// input register still fills once, and req_stall rises only when both
// registers are full.
`default_nettype none

module spdif_bmc_frame_encoder_top #(
   parameter int FRAMES_PER_BLOCK = 192
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire sbmc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output sbmc_pkg::rsp_type      rsp_data
);

   localparam int SampleCount = 2 * FRAMES_PER_BLOCK;
   localparam int IdxWidth    = $clog2(SampleCount);
   localparam logic [IdxWidth-1:0] LastIdx = IdxWidth'(SampleCount - 1);
   localparam logic [IdxWidth-1:0] IdxOne  = IdxWidth'(1);

   logic [IdxWidth-1:0] sample_index_ff, sample_index_in;
   logic                in_valid_ff, in_valid_in;
   sbmc_pkg::req_type   in_data_ff, in_data_in;
   sbmc_pkg::slot_type  in_slot_ff, in_slot_in;
   logic                out_valid_ff, out_valid_in;
   sbmc_pkg::rsp_type   out_data_ff, out_data_in;
   sbmc_pkg::rsp_type   frame;
   logic                req_take;
   logic                out_load;

   // handshake
   assign out_load  = ~out_valid_ff | ~rsp_stall;
   assign req_stall = in_valid_ff & ~out_load;
   assign req_take  = req_valid & ~req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // sample counter, advances on each input transfer
   always_comb begin
      sample_index_in = sample_index_ff;
      if (req_take) begin
         if (sample_index_ff == LastIdx) begin
            sample_index_in = '0;
         end else begin
            sample_index_in = sample_index_ff + IdxOne;
         end
      end
   end

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      in_slot_in  = in_slot_ff;
      if (req_take) begin
         in_valid_in            = 1'b1;
         in_data_in             = req_data;
         in_slot_in.block_start = (sample_index_ff == '0);
         in_slot_in.odd_sample  = sample_index_ff[0];
      end else if (out_load) begin
         in_valid_in = 1'b0;
      end
   end

   sbmc_word_encoder u_encoder (
      .sample (in_data_ff),
      .slot   (in_slot_ff),
      .frame  (frame)
   );

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_load) begin
         out_valid_in = in_valid_ff;
         out_data_in  = frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_index_ff <= '0;
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         sample_index_ff <= sample_index_in;
         in_valid_ff     <= in_valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      in_slot_ff  <= in_slot_in;
      out_data_ff <= out_data_in;
   end

endmodule

`default_nettype wire
